// ===== design/tml_pkg.sv =====
package tml_pkg;

    localparam int NumWeights    = 33;
    localparam int WIdxW         = 6;
    localparam int MaxCandidates = 256;
    localparam int CntW          = $clog2(MaxCandidates + 1);

    localparam logic [CntW-1:0] CntMax = CntW'(MaxCandidates);
    localparam logic [CntW-1:0] CntOne = CntW'(1);

    localparam logic [2:0] CmdLoad   = 3'd0;
    localparam logic [2:0] CmdEval   = 3'd1;
    localparam logic [2:0] CmdLearnI = 3'd2;
    localparam logic [2:0] CmdLearnS = 3'd3;
    localparam logic [2:0] CmdSelect = 3'd4;

    localparam logic RegRateInd = 1'b0;
    localparam logic RegRateSoc = 1'b1;

    typedef struct packed {
        logic [2:0]         command;
        logic [5:0]         weight_index;
        logic signed [23:0] weight_value;
        logic signed [23:0] cue;
        logic signed [23:0] target;
        logic               last_candidate;
    } t_in;

    typedef struct packed {
        logic signed [23:0] estimate;
        logic signed [23:0] error_value;
        logic [7:0]         best_index;
        logic               run_done;
    } t_out;

    function automatic logic signed [23:0] sat24(input logic signed [49:0] x);
        if (x > 50'sd8388607) begin
            return 24'sd8388607;
        end else if (x < -50'sd8388608) begin
            return -24'sd8388608;
        end
        return x[23:0];
    endfunction

endpackage

// ===== design/tml_ram.sv =====
module tml_ram #(
    parameter int Width = 24,
    parameter int Depth = 33
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== design/tiny_mlp_delta_rule_learner.sv =====
// Input is ready again as the result is presented, so a new item is taken only once the
// result of the last one has been presented. Load and unused commands go straight to the
// result. One shared 24x25 multiply-accumulate walks the 33 weight reads of the forward
// pass (9 biases, 24 products) in turn; learn then updates the four output weights one by
// one through S_UPD and S_WB. A result that is not taken holds the next one back.
// Reset clears rates, run state and result; then S_CLEAR writes zero to every weight.
module tiny_mlp_delta_rule_learner (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tml_pkg::t_in       i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tml_pkg::t_out      o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_MAC, S_ACT, S_OUT, S_UPD, S_WB, S_DONE
    } t_state;

    t_state r_state;
    tml_pkg::t_in r_item;
    tml_pkg::t_out r_res;
    logic [15:0] r_rate_i, r_rate_s;
    logic [5:0] r_addr;
    logic [5:0] r_step;
    logic signed [49:0] r_acc;
    logic [16:0] r_h [4];
    logic [16:0] r_g [4];
    logic signed [23:0] r_outsat, r_err;
    logic signed [41:0] r_outv;
    logic signed [23:0] r_best;
    logic [7:0] r_bpos;
    logic [tml_pkg::CntW-1:0] r_cnt;
    logic [1:0] r_j;
    logic [1:0] r_phase;
    logic signed [41:0] r_prod2;

    logic we;
    logic [5:0] waddr;
    logic [23:0] wdata, rdata;

    tml_ram #(.Width(24), .Depth(tml_pkg::NumWeights)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(r_addr), .o_rdata(rdata)
    );

    // Schedule of reads: step s reads address addr_of(s)
    // steps 0..7: h_i (bias i, weight 9+i)
    // steps per node: bias then products; order encoded in table
    function automatic logic [5:0] addr_of(input logic [5:0] s);
        logic [5:0] a;
        if (s < 6'd8) begin
            a = s[0] ? 6'd9 + {4'd0, s[2:1]} : {4'd0, s[2:1]};
        end else if (s < 6'd28) begin
            // 5 reads per g node: bias 4+j, then 13+4i+j
            a = 6'd0;
            for (int k = 0; k < 20; k++) begin
                if (s == 6'(8 + k)) begin
                    a = (k % 5 == 0) ? 6'(4 + k / 5) : 6'(13 + 4 * (k % 5 - 1) + k / 5);
                end
            end
        end else begin
            a = (s == 6'd28) ? 6'd8 : 6'(29 + s - 29);
        end
        return a;
    endfunction

    // {bias, last of node, operand select, node} for the read of step p
    function automatic logic [5:0] dec_of(input logic [5:0] p);
        logic [5:0] d;
        if (p < 6'd8) begin
            d = {!p[0], p[0], 2'd0, p[2:1]};
        end else if (p < 6'd28) begin
            d = 6'd0;
            for (int k = 0; k < 20; k++) begin
                if (p == 6'(8 + k)) begin
                    d = {k % 5 == 0, k % 5 == 4, 2'(k % 5 - 1), 2'(k / 5)};
                end
            end
        end else begin
            d = {p == 6'd28, 1'b0, 2'(p - 6'd29), 2'd0};
        end
        return d;
    endfunction

    // Multiplier operand for a read at step s
    logic signed [24:0] mop;
    logic signed [49:0] prod;
    logic [5:0] ps;
    logic [5:0] dec;
    logic is_bias;
    always_comb begin
        ps = r_step - 6'd1;
        dec = dec_of(ps);
        is_bias = dec[5];
        if (ps < 6'd8) begin
            mop = {r_item.cue[23], r_item.cue};
        end else if (ps < 6'd28) begin
            mop = {8'd0, r_h[dec[3:2]]};
        end else begin
            mop = {8'd0, r_g[dec[3:2]]};
        end
        prod = is_bias ? 50'(signed'(rdata)) <<< 16 : 50'(signed'(rdata)) * 50'(mop);
    end

    logic last_of_node;
    always_comb begin
        last_of_node = dec[4];
    end

    function automatic logic [16:0] act(input logic signed [49:0] s);
        if (s < 0) return 17'd0;
        if (s > 50'sd4294967296) return 17'd65536;
        return s[32:16];
    endfunction

    logic signed [49:0] acc_n;
    assign acc_n = r_acc + prod;

    // update datapath
    logic [15:0] rate;
    logic signed [23:0] wsum_sat;
    logic signed [59:0] dprod;
    logic signed [49:0] delta;
    assign rate = (r_item.command == tml_pkg::CmdLearnI) ? r_rate_i : r_rate_s;
    assign dprod = 60'(r_prod2) * 60'(signed'({1'b0, r_g[r_j]}));
    assign delta = 50'(dprod >>> 32);
    assign wsum_sat = tml_pkg::sat24(50'(signed'(rdata)) + delta);

    // select run bookkeeping
    logic sel_take;
    assign sel_take = (r_cnt < tml_pkg::CntMax) && (r_cnt == '0 || r_outsat > r_best);

    always_comb begin
        we = 1'b0;
        waddr = r_addr;
        wdata = '0;
        if (r_state == S_CLEAR) begin
            we = 1'b1;
        end else if (r_state == S_IDLE && i_in_valid
                     && i_in_data.command == tml_pkg::CmdLoad
                     && i_in_data.weight_index < 6'(tml_pkg::NumWeights)) begin
            we = 1'b1;
            waddr = i_in_data.weight_index;
            wdata = i_in_data.weight_value;
        end else if (r_state == S_WB) begin
            we = 1'b1;
            waddr = 6'd29 + {4'd0, r_j};
            wdata = wsum_sat;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    logic signed [41:0] diff;
    assign diff = 42'(r_item.target) - r_outv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr <= '0;
            r_rate_i <= '0;
            r_rate_s <= '0;
            r_best <= '0;
            r_bpos <= '0;
            r_cnt <= '0;
            o_out_valid <= 1'b0;
            o_out_data <= '0;
            r_step <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == tml_pkg::RegRateInd) r_rate_i <= i_cfg_data;
                else r_rate_s <= i_cfg_data;
            end
            if (r_state == S_DONE && (!o_out_valid || i_out_ready)) begin
                o_out_valid <= 1'b1;
                o_out_data <= r_res;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + 6'd1;
                    if (r_addr == 6'(tml_pkg::NumWeights - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item <= i_in_data;
                        r_step <= '0;
                        r_addr <= '0;
                        r_acc <= '0;
                        if (i_in_data.command == tml_pkg::CmdEval
                            || i_in_data.command == tml_pkg::CmdLearnI
                            || i_in_data.command == tml_pkg::CmdLearnS
                            || i_in_data.command == tml_pkg::CmdSelect) begin
                            r_state <= S_MAC;
                        end else begin
                            r_res <= '0;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_MAC: begin
                    r_step <= r_step + 6'd1;
                    r_addr <= addr_of(r_step + 6'd1);
                    if (r_step != 6'd0) begin
                        if (last_of_node) begin
                            r_acc <= '0;
                            if (ps < 6'd8) r_h[dec[1:0]] <= act(acc_n);
                            else r_g[dec[1:0]] <= act(acc_n);
                        end else begin
                            r_acc <= acc_n;
                        end
                        if (ps == 6'd32) begin
                            r_outv <= 42'(acc_n >>> 16);
                            r_state <= S_ACT;
                        end
                    end
                end
                S_ACT: begin
                    r_outsat <= tml_pkg::sat24(50'(r_outv));
                    r_err <= tml_pkg::sat24(50'(diff));
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_res.estimate <= r_outsat;
                    if (r_item.command == tml_pkg::CmdSelect) begin
                        r_res.error_value <= '0;
                        r_res.best_index <= sel_take ? 8'(r_cnt) : r_bpos;
                        r_res.run_done <= r_item.last_candidate;
                        r_state <= S_DONE;
                        if (r_item.last_candidate) begin
                            r_best <= '0;
                            r_bpos <= '0;
                            r_cnt <= '0;
                        end else begin
                            if (sel_take) begin
                                r_best <= r_outsat;
                                r_bpos <= 8'(r_cnt);
                            end
                            if (r_cnt < tml_pkg::CntMax) r_cnt <= r_cnt + tml_pkg::CntOne;
                        end
                    end else if (r_item.command == tml_pkg::CmdEval) begin
                        r_res.error_value <= '0;
                        r_res.best_index <= '0;
                        r_res.run_done <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_res.error_value <= r_err;
                        r_res.best_index <= '0;
                        r_res.run_done <= 1'b0;
                        r_j <= '0;
                        r_phase <= '0;
                        r_addr <= 6'd29;
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    // phase 0: rate*err, phase 1: read settles
                    r_prod2 <= 42'(signed'({1'b0, rate})) * 42'(r_err);
                    r_phase <= r_phase + 2'd1;
                    if (r_phase == 2'd1) r_state <= S_WB;
                end
                S_WB: begin
                    r_j <= r_j + 2'd1;
                    r_phase <= '0;
                    r_addr <= 6'd29 + {4'd0, r_j + 2'd1};
                    r_state <= (r_j == 2'd3) ? S_DONE : S_UPD;
                end
                S_DONE: begin
                    if (!o_out_valid || i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready) else $error("ready while busy");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= tml_pkg::CntMax) else $error("candidate count overflow");
    a_done_one_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!o_out_valid || i_out_ready)) |=> o_out_valid)
        else $error("result lost");
endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    tml_pkg::t_in i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    tml_pkg::t_out o_out_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data = '0;

    tiny_mlp_delta_rule_learner dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic signed [23:0] net_w [tml_pkg::NumWeights];
    logic signed [23:0] sel_best;
    int unsigned sel_pos;
    int unsigned sel_count;
    logic [15:0] rate_ind;
    logic [15:0] rate_soc;

    tml_pkg::t_in word_q[$];
    tml_pkg::t_out expected_q[$];
    int errors = 0;
    bit feed_hold = 1'b0;
    bit sink_hold = 1'b0;
    bit hold_start = 1'b0;
    int in_gap = 0;
    int out_gap = 0;

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [63:0] sat_q24(input logic signed [63:0] x);
        if (x > 64'sd8388607) return 64'sd8388607;
        if (x < -64'sd8388608) return -64'sd8388608;
        return x;
    endfunction

    function automatic logic signed [63:0] clamp_unit(input logic signed [63:0] s);
        if (s < 0) s = 0;
        if (s > 64'sd4294967296) s = 64'sd4294967296;
        return s >>> 16;
    endfunction

    function automatic logic signed [63:0] forward(input logic signed [23:0] cue,
                                                    output logic signed [63:0] g [4]);
        logic signed [63:0] h [4];
        logic signed [63:0] acc;
        for (int i = 0; i < 4; i++) begin
            acc = 64'(net_w[i]) * 65536 + 64'(net_w[9 + i]) * 64'(cue);
            h[i] = clamp_unit(acc);
        end
        for (int j = 0; j < 4; j++) begin
            acc = 64'(net_w[4 + j]) * 65536;
            for (int i = 0; i < 4; i++) acc += 64'(net_w[13 + 4 * i + j]) * h[i];
            g[j] = clamp_unit(acc);
        end
        acc = 64'(net_w[8]) * 65536;
        for (int j = 0; j < 4; j++) acc += 64'(net_w[29 + j]) * g[j];
        return acc >>> 16;
    endfunction

    function automatic tml_pkg::t_out predict_result(input tml_pkg::t_in w);
        tml_pkg::t_out r;
        logic signed [63:0] g [4];
        logic signed [63:0] outv, est, err, d;
        logic [15:0] rate;
        r = '0;
        case (w.command)
            tml_pkg::CmdLoad: begin
                if (w.weight_index < tml_pkg::NumWeights) begin
                    net_w[w.weight_index] = w.weight_value;
                end
            end
            tml_pkg::CmdEval: r.estimate = 24'(sat_q24(forward(w.cue, g)));
            tml_pkg::CmdLearnI, tml_pkg::CmdLearnS: begin
                outv = forward(w.cue, g);
                rate = (w.command == tml_pkg::CmdLearnI) ? rate_ind : rate_soc;
                r.estimate = 24'(sat_q24(outv));
                err = sat_q24(64'(w.target) - outv);
                r.error_value = 24'(err);
                for (int j = 0; j < 4; j++) begin
                    d = ($signed(64'(rate)) * err * g[j]) >>> 32;
                    net_w[29 + j] = 24'(sat_q24(64'(net_w[29 + j]) + d));
                end
            end
            tml_pkg::CmdSelect: begin
                est = sat_q24(forward(w.cue, g));
                r.estimate = 24'(est);
                if (sel_count < tml_pkg::MaxCandidates) begin
                    if (sel_count == 0 || est > 64'(sel_best)) begin
                        sel_best = 24'(est);
                        sel_pos = sel_count;
                    end
                    sel_count++;
                end
                r.best_index = 8'(sel_pos);
                r.run_done = w.last_candidate;
                if (w.last_candidate) begin
                    sel_best = '0;
                    sel_pos = 0;
                    sel_count = 0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            expected_q.push_back(predict_result(i_in_data));
        end
        if (!i_in_valid || o_in_ready) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (!feed_hold && word_q.size() > 0 && i_rst_n) begin
                i_in_data <= word_q.pop_front();
                i_in_valid <= 1'b1;
                in_gap <= rand_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        tml_pkg::t_out e;
        if (o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected word %h", o_out_data);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (o_out_data.estimate !== e.estimate) begin
                    $error("estimate exp %0d got %0d", e.estimate, o_out_data.estimate);
                    errors++;
                end
                if (o_out_data.error_value !== e.error_value) begin
                    $error("error_value exp %0d got %0d", e.error_value,
                           o_out_data.error_value);
                    errors++;
                end
                if (o_out_data.best_index !== e.best_index) begin
                    $error("best_index exp %0d got %0d", e.best_index,
                           o_out_data.best_index);
                    errors++;
                end
                if (o_out_data.run_done !== e.run_done) begin
                    $error("run_done exp %0d got %0d", e.run_done, o_out_data.run_done);
                    errors++;
                end
            end
        end
        if (sink_hold) begin
            i_out_ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            out_gap <= rand_gap();
        end
    end

    initial begin
        wait (hold_start);
        sink_hold = 1'b1;
        repeat (300) @(posedge i_clk);
        sink_hold = 1'b0;
    end

    function automatic logic signed [23:0] rand_q();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 24'sh7fffff;
        if (r == 1) return 24'sh800000;
        if (r < 6) return 24'($signed($urandom_range(0, 262143)) - 131072);
        return 24'($urandom);
    endfunction

    function automatic tml_pkg::t_in make_word(input logic [2:0] cmd);
        tml_pkg::t_in w;
        w = '0;
        w.command = cmd;
        w.weight_index = 6'($urandom);
        w.weight_value = 24'($urandom);
        w.cue = rand_q();
        w.target = rand_q();
        w.last_candidate = 1'b0;
        if (cmd == tml_pkg::CmdLoad) begin
            w.weight_index = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(33, 63))
                                                          : 6'($urandom_range(0, 32));
            w.weight_value = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                : 24'($signed($urandom_range(0, 196608)) - 98304);
        end
        return w;
    endfunction

    task automatic drain();
        wait (word_q.size() == 0);
        @(posedge i_clk);
        while (i_in_valid || expected_q.size() > 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_rate(input logic idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == tml_pkg::RegRateInd) rate_ind = val;
        else rate_soc = val;
    endtask

    initial begin
        tml_pkg::t_in w;
        int n;
        int r;
        bit paused;
        paused = 1'b0;
        for (int i = 0; i < tml_pkg::NumWeights; i++) net_w[i] = '0;
        sel_best = '0;
        sel_pos = 0;
        sel_count = 0;
        rate_ind = '0;
        rate_soc = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_rate(tml_pkg::RegRateInd, 16'hffff);
        write_rate(tml_pkg::RegRateSoc, 16'h0000);

        for (int i = 0; i < tml_pkg::NumWeights; i++) begin
            w = make_word(tml_pkg::CmdLoad);
            w.weight_index = 6'(i);
            word_q.push_back(w);
        end
        w = make_word(tml_pkg::CmdLoad);
        w.weight_index = 6'd63;
        w.weight_value = 24'sh7fffff;
        word_q.push_back(w);
        w = make_word(tml_pkg::CmdEval); w.cue = 24'sh7fffff; word_q.push_back(w);
        w = make_word(tml_pkg::CmdEval); w.cue = 24'sh800000; word_q.push_back(w);
        w = make_word(tml_pkg::CmdLearnI); w.target = 24'sh7fffff; word_q.push_back(w);
        w = make_word(tml_pkg::CmdLearnS); w.target = 24'sh800000; word_q.push_back(w);
        for (int i = 0; i < 3; i++) begin
            w = make_word(tml_pkg::CmdSelect);
            w.cue = (i == 1) ? 24'sh010000 : 24'sh0;
            w.last_candidate = (i == 2);
            word_q.push_back(w);
        end
        for (int c = 5; c < 8; c++) word_q.push_back(make_word(3'(c)));
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_rate(tml_pkg::RegRateInd, 16'h0000);
                    write_rate(tml_pkg::RegRateSoc, 16'hffff);
                end
                1: begin
                    write_rate(tml_pkg::RegRateInd, 16'h0400);
                    write_rate(tml_pkg::RegRateSoc, 16'h1000);
                end
                2: begin
                    write_rate(tml_pkg::RegRateInd, 16'($urandom));
                    write_rate(tml_pkg::RegRateSoc, 16'($urandom));
                end
                default: begin
                    write_rate(tml_pkg::RegRateInd, 16'hffff);
                    write_rate(tml_pkg::RegRateSoc, 16'hffff);
                end
            endcase
            n = 0;
            while (n < 220) begin
                r = $urandom_range(0, 99);
                if (r < 15) word_q.push_back(make_word(tml_pkg::CmdLoad));
                else if (r < 30) word_q.push_back(make_word(tml_pkg::CmdEval));
                else if (r < 45) word_q.push_back(make_word(tml_pkg::CmdLearnI));
                else if (r < 60) word_q.push_back(make_word(tml_pkg::CmdLearnS));
                else if (r < 97) begin
                    int len;
                    len = (phase == 3 && n == 0) ? 260 : $urandom_range(1, 8);
                    for (int k = 0; k < len; k++) begin
                        w = make_word(tml_pkg::CmdSelect);
                        w.last_candidate = (k == len - 1);
                        word_q.push_back(w);
                        if (k % 4 == 1 && $urandom_range(0, 5) == 0)
                            word_q.push_back(make_word(tml_pkg::CmdEval));
                    end
                    n += len - 1;
                end else word_q.push_back(make_word(3'($urandom_range(5, 7))));
                n++;
                if (n >= 40 && phase == 1) hold_start = 1'b1;
                if (n >= 100 && phase == 2 && !paused) begin
                    paused = 1'b1;
                    repeat (1500) @(posedge i_clk);
                    feed_hold = 1'b1;
                    while (i_in_valid || expected_q.size() > 0) @(posedge i_clk);
                    feed_hold = 1'b0;
                end
            end
            drain();
        end

        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
